FILE: rtl/core/bsa_pkg.sv
// Shared types and constants for the ascending list sorter.
// Used by bsa_cell and bubble_sort_ascending; no dependencies.
package bsa_pkg;

    // Default list depth
    localparam int LIST_DEPTH_DEF = 64;
    localparam int VALUE_W        = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Input transfer payload
    typedef struct packed {
        t_value value;
        logic   is_last;
    } t_item;

    // Result transfer payload
    typedef struct packed {
        t_value sorted_value;
        logic   is_final;
        logic   overflow;
    } t_result;

    // Element moving down the cell chain
    typedef struct packed {
        logic   vld;
        t_value value;
    } t_pass;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_DRAIN  = 3'b100
    } t_state;

endpackage

FILE: rtl/core/bsa_cell.sv
// One cell of the insertion chain: keeps the smaller element, passes the larger on.
// Also shifts toward the head during unload. Depends on bsa_pkg.
module bsa_cell
    import bsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_pass      i_pass,
    input  t_value     i_right,
    output t_value     o_value,
    output t_pass      o_pass
);

    t_value r_value, n_value;
    logic   r_full,  n_full;
    t_pass  r_pass,  n_pass;

    // Compare-and-pass; ties keep the held element so equal values stay in order
    always_comb begin
        n_value      = r_value;
        n_full       = r_full;
        n_pass.vld   = 1'b0;
        n_pass.value = i_pass.value;
        if (i_ctrl.clear) begin
            n_full = 1'b0;
        end else if (i_ctrl.shift) begin
            n_value = i_right;
        end else if (i_pass.vld) begin
            if (!r_full) begin
                n_value = i_pass.value;
                n_full  = 1'b1;
            end else if (r_value > i_pass.value) begin
                n_value      = i_pass.value;
                n_pass.vld   = 1'b1;
                n_pass.value = r_value;
            end else begin
                n_pass.vld = 1'b1;
            end
        end
    end

    // Control bits are reset; payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_pass.vld <= 1'b0;
        end else begin
            r_full     <= n_full;
            r_pass.vld <= n_pass.vld;
        end
        r_value      <= n_value;
        r_pass.value <= n_pass.value;
    end

    assign o_value = r_value;
    assign o_pass  = r_pass;

endmodule

FILE: rtl/core/bubble_sort_ascending.sv
// Ascending stable list sorter built as a systolic insertion chain of LIST_DEPTH cells.
// Loading takes one element per cycle (busy low); elements sort as they travel the chain.
// After the last element the chain settles, then the list drains one result per cycle from the head;
// results are registered, and the settle time is set by the chain length.
// Synchronous active-low reset empties the list; results cannot be stalled by the receiver.
module bubble_sort_ascending
    import bsa_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state         r_state,  n_state;
    logic [CW-1:0]  r_count,  n_count;
    logic [CW-1:0]  r_remain, n_remain;
    logic           r_ovf,    n_ovf;
    logic           r_strobe, n_strobe;
    t_result        r_result, n_result;

    t_cell_ctrl w_ctrl;
    t_pass      w_chain [LIST_DEPTH+1];
    t_value     w_value [LIST_DEPTH];
    t_value     w_right [LIST_DEPTH];
    logic       w_accept;
    logic       w_room;

    assign busy     = (r_state != ST_LOAD);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < DEPTH_C);

    // Injection into the head of the chain
    assign w_chain[0].vld   = w_accept && w_room;
    assign w_chain[0].value = i_item.value;

    // Cell chain
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        if (g == LIST_DEPTH - 1) begin : g_tail
            assign w_right[g] = w_value[g];
        end else begin : g_mid
            assign w_right[g] = w_value[g+1];
        end
        bsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_pass  (w_chain[g]),
            .i_right (w_right[g]),
            .o_value (w_value[g]),
            .o_pass  (w_chain[g+1])
        );
    end

    // Sequencer: load, let the chain settle, then drain from the head
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_remain = r_remain;
        n_ovf    = r_ovf;
        n_strobe = 1'b0;
        n_result = r_result;
        w_ctrl   = '0;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + ONE_C;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.is_last) begin
                        n_remain = w_room ? (r_count + ONE_C) : r_count;
                        n_count  = DEPTH_C;
                        n_state  = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                // r_count reused as settle timer
                n_count = r_count - ONE_C;
                if (r_count == ONE_C) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_strobe              = 1'b1;
                n_result.sorted_value = w_value[0];
                n_result.is_final     = (r_remain == ONE_C);
                n_result.overflow     = r_ovf;
                n_remain              = r_remain - ONE_C;
                w_ctrl.shift          = 1'b1;
                if (r_remain == ONE_C) begin
                    w_ctrl.clear = 1'b1;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_remain <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
